// ----- rtl/substring_find_replace_defines.svh -----
// Assertion macros shared by the find-and-replace modules.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef SUBSTRING_FIND_REPLACE_DEFINES_SVH
`define SUBSTRING_FIND_REPLACE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("find-replace: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("find-replace: next-cycle check failed");

`endif

// ----- rtl/sfr_pkg.sv -----
package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 3'd0,
        CFG_PATTERN_LENGTH     = 3'd1,
        CFG_REPLACEMENT_BYTES  = 3'd2,
        CFG_REPLACEMENT_LENGTH = 3'd3,
        CFG_REPLACE_EVERY      = 3'd4
    } t_cfg_idx;

    // Settings as seen by the datapath, lengths already saturated.
    typedef struct packed {
        logic [CFG_W-1:0] pattern;
        logic [CNT_W-1:0] plen;
        logic [CFG_W-1:0] repl;
        logic [CNT_W-1:0] rlen;
        logic             every;
    } t_cfg;

    // Control half of one burst of results handed to the serialiser.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             done;
        logic             bare;
    } t_burst_ctl;

endpackage

// ----- rtl/sfr_cfg.sv -----
module sfr_cfg
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [CFG_W-1:0] r_pattern;
    logic [CNT_W-1:0] r_plen;
    logic [CFG_W-1:0] r_repl;
    logic [CNT_W-1:0] r_rlen;
    logic             r_every;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= '0;
            r_repl    <= '0;
            r_rlen    <= '0;
            r_every   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_BYTES:      r_pattern <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_plen    <= i_cfg_data[CNT_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_repl    <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rlen    <= i_cfg_data[CNT_W-1:0];
                CFG_REPLACE_EVERY:      r_every   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Lengths beyond the hardware limits behave as the limits.
    always_comb begin
        o_cfg.pattern = r_pattern;
        o_cfg.repl    = r_repl;
        o_cfg.every   = r_every;
        o_cfg.plen    = (r_plen > CNT_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX) : r_plen;
        o_cfg.rlen    = (r_rlen > CNT_W'(REPLACE_MAX)) ? CNT_W'(REPLACE_MAX) : r_rlen;
    end

endmodule

// ----- rtl/sfr_match.sv -----
`include "substring_find_replace_defines.svh"

module sfr_match
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8,
    localparam int BURST_N = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_string_end,
    output logic [BYTE_W-1:0] o_bytes [BURST_N],
    output t_burst_ctl        o_ctl
);

    logic [BYTE_W-1:0] r_win [PATTERN_MAX];
    logic [BYTE_W-1:0] n_win [PATTERN_MAX];
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_once, n_once;

    logic [BYTE_W-1:0] ext [PATTERN_MAX];
    logic [CNT_W-1:0]  fill;
    logic              all_eq, at_len, over, hit;

    // Window with the new byte placed after the held ones.
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            ext[i] = (CNT_W'(i) == r_cnt) ? i_text_byte : r_win[i];
        end
    end

    always_comb begin
        fill   = r_cnt + CNT_W'(1);
        at_len = (fill == i_cfg.plen);
        over   = (fill > i_cfg.plen);
        all_eq = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (CNT_W'(i) < i_cfg.plen && ext[i] != i_cfg.pattern[BYTE_W*i +: BYTE_W]) begin
                all_eq = 1'b0;
            end
        end
        hit = at_len && all_eq && (i_cfg.every || !r_once);
    end

    always_comb begin
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_once     = r_once;
        o_ctl.cnt  = '0;
        o_ctl.done = i_string_end;
        o_ctl.bare = 1'b0;
        for (int i = 0; i < BURST_N; i++) begin
            if (hit) begin
                o_bytes[i] = i_cfg.repl[BYTE_W*i +: BYTE_W];
            end else if (i < PATTERN_MAX) begin
                o_bytes[i] = ext[i % PATTERN_MAX];
            end else begin
                o_bytes[i] = '0;
            end
        end

        if (hit) begin
            n_cnt     = '0;
            n_once    = 1'b1;
            o_ctl.cnt = i_cfg.rlen;
        end else if (over || at_len) begin
            // Oldest byte leaves; the count stays as it was.
            for (int i = 0; i < PATTERN_MAX; i++) begin
                n_win[i] = (i + 1 < PATTERN_MAX) ? ext[(i + 1) % PATTERN_MAX] : ext[i];
            end
            o_ctl.cnt = CNT_W'(1);
        end else begin
            n_win = ext;
            n_cnt = fill;
        end

        if (i_string_end) begin
            n_cnt  = '0;
            n_once = 1'b0;
            if (!hit) begin
                // The whole window, new byte included, is flushed in order.
                o_ctl.cnt = fill;
            end else if (i_cfg.rlen == '0) begin
                o_ctl.cnt  = CNT_W'(1);
                o_ctl.bare = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_once <= 1'b0;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_once <= n_once;
        end
    end

    `SFR_ASSERT_NOW(a_win_room, 1'b1, r_cnt < CNT_W'(PATTERN_MAX))
    `SFR_ASSERT_NEXT(a_end_clears, i_accept && i_string_end, r_cnt == '0 && !r_once)

endmodule

// ----- rtl/sfr_serial.sv -----
`include "substring_find_replace_defines.svh"

module sfr_serial
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8,
    localparam int BURST_N = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [BYTE_W-1:0] i_bytes [BURST_N],
    input  t_burst_ctl        i_ctl,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_string_done,
    output logic              o_run_last
);

    logic [BYTE_W-1:0] r_bytes [BURST_N];
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done, r_bare;
    logic              r_ov;
    logic [BYTE_W-1:0] r_ob;
    logic              r_obv, r_od, r_ol;
    logic              move, last;

    assign last    = (r_cnt == CNT_W'(1));
    assign move    = (r_cnt != '0) && (!r_ov || !i_stall);
    assign o_ready = (r_cnt == '0) || (last && move);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_bytes;
            r_done  <= i_ctl.done;
            r_bare  <= i_ctl.bare;
        end else if (move) begin
            for (int i = 0; i < BURST_N; i++) begin
                r_bytes[i] <= (i + 1 < BURST_N) ? r_bytes[(i + 1) % BURST_N] : r_bytes[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_ctl.cnt;
        end else if (move) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (move) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_ob  <= r_bare ? '0 : r_bytes[0];
            r_obv <= !r_bare;
            r_od  <= r_done && last;
            r_ol  <= last;
        end
    end

    assign o_valid       = r_ov;
    assign o_out_byte    = r_ob;
    assign o_byte_valid  = r_obv;
    assign o_string_done = r_od;
    assign o_run_last    = r_ol;

    `SFR_ASSERT_NOW(a_load_free, i_load, r_cnt == '0 || (last && move))
    `SFR_ASSERT_NOW(a_bare_final, r_ov && !r_obv, r_od && r_ol)
    `SFR_ASSERT_NEXT(a_run_continues, r_ov && !r_ol && !i_stall, r_ov)

endmodule

// ----- rtl/substring_find_replace.sv -----
// Streaming substring find-and-replace, one text byte per input transfer.
// Input channel: i_valid / o_stall carry i_text_byte and i_string_end; a byte
// is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_out_byte, o_byte_valid,
// o_string_done and o_run_last; a result moves at an edge with o_valid high
// and i_stall low. o_run_last marks the final result caused by one input byte.
// Configuration: i_cfg_we writes i_cfg_data into the register chosen by
// i_cfg_index (pattern, pattern length, replacement, replacement length,
// replace-every). Write only while the block is idle.
// A byte's results go through the burst register to the output register.
// Throughput is one byte per cycle while each byte yields at most one result
// and i_stall is low; a byte with more results (a replacement or a string-end
// flush) holds the input until its last result leaves the one-result output port.
// A burst register feeds the output register, so a byte is taken while a result
// waits on a stalled receiver if the burst is empty; a stalled result holds steady.
// Reset is synchronous and active low: the window empties, the first-match
// flag clears and both lengths return to zero, so bytes pass through.
module substring_find_replace
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_text_byte,
    input  logic                 i_string_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_string_done,
    output logic                 o_run_last
);

    // A burst holds every result one byte can cause.
    localparam int BURST_N = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

    t_cfg              cfg;
    t_burst_ctl        burst_ctl;
    logic [BYTE_W-1:0] burst_bytes [BURST_N];
    logic              ready;
    logic              accept;

    // A byte is taken only when the burst register is empty or hands over
    // its last result in this very cycle.
    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    sfr_cfg #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The window compare and the choice of results happen in one pass.
    sfr_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (accept),
        .i_text_byte  (i_text_byte),
        .i_string_end (i_string_end),
        .o_bytes      (burst_bytes),
        .o_ctl        (burst_ctl)
    );

    // The serialiser releases a burst one result per transfer.
    sfr_serial #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_bytes       (burst_bytes),
        .i_ctl         (burst_ctl),
        .o_ready       (ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_string_done (o_string_done),
        .o_run_last    (o_run_last)
    );

endmodule
